/* rtl/aosp_pkg.sv */
package aosp_pkg;

   // Field widths
   localparam int VOLT_RAW_W  = 11;
   localparam int CURR_RAW_W  = 12;
   localparam int LIGHT_RAW_W = 12;
   localparam int TEMP_RAW_W  = 11;
   localparam int MEAS_W      = 16;
   localparam int TEMP_OUT_W  = 17;
   localparam int SCALE_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // Defaults for the top level parameters
   localparam int BLOCK_SAMPLES_DEF = 64;
   localparam int SUM_SHIFT_DEF     = 4;

   // Kelvin-to-Celsius offset in tenths
   localparam logic [TEMP_OUT_W-1:0] TEMP_OFFSET = 17'd2730;

   // Tracker reset values
   localparam logic [VOLT_RAW_W-1:0] MIN_TRACK_RESET = 11'd2047;
   localparam logic [VOLT_RAW_W-1:0] MAX_TRACK_RESET = 11'd0;

   // Scale register reset values
   localparam logic [SCALE_W-1:0] VOLTAGE_SCALE_RST = 16'd52822;
   localparam logic [SCALE_W-1:0] CURRENT_SCALE_RST = 16'd33341;
   localparam logic [SCALE_W-1:0] LIGHT_SCALE_RST   = 16'd33341;
   localparam logic [SCALE_W-1:0] TEMP_SCALE_RST    = 16'd0;

   // Rounding constant for Q16 products
   localparam logic [2*SCALE_W-1:0] Q16_HALF = 32'h0000_8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLTAGE_SCALE,
      CSR_CURRENT_SCALE,
      CSR_LIGHT_SCALE,
      CSR_TEMPERATURE_SCALE
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE,
      CMD_READ_PEAKS
   } cmd_type;

endpackage

/* rtl/aosp_if.sv */
interface aosp_req_if import aosp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic        [VOLT_RAW_W-1:0]  voltage_raw;
   logic signed [CURR_RAW_W-1:0]  current_raw;
   logic signed [LIGHT_RAW_W-1:0] light_raw;
   logic        [TEMP_RAW_W-1:0]  temperature_raw;

   modport source (output valid, cmd, voltage_raw, current_raw, light_raw, temperature_raw,
                   input ready);
   modport sink (input valid, cmd, voltage_raw, current_raw, light_raw, temperature_raw,
                 output ready);
endinterface

interface aosp_rsp_if import aosp_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         measure_ready;
   logic        [MEAS_W-1:0]     voltage_mv;
   logic        [MEAS_W-1:0]     current_ma;
   logic        [MEAS_W-1:0]     light_lux;
   logic signed [TEMP_OUT_W-1:0] temperature_tenths;
   logic        [MEAS_W-1:0]     min_voltage_mv;
   logic        [MEAS_W-1:0]     max_current_ma;

   modport source (output valid, measure_ready, voltage_mv, current_ma, light_lux,
                   temperature_tenths, min_voltage_mv, max_current_ma,
                   input ready);
   modport sink (input valid, measure_ready, voltage_mv, current_ma, light_lux,
                 temperature_tenths, min_voltage_mv, max_current_ma,
                 output ready);
endinterface

interface aosp_csr_if import aosp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/adc_oversample_scale_peak_top.sv */
// Accepted items pass the stage 1 register, then the result register.
// Throughput: one item per cycle; the two stages advance together and stall
// only when the result register holds an item not yet taken.
// Reset: synchronous, active high; clears sums, block counter, trackers, held
// measurements and pipeline valids, and loads the scale registers' defaults.
module adc_oversample_scale_peak_top
   import aosp_pkg::*;
#(
   parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
   parameter int SUM_SHIFT     = SUM_SHIFT_DEF
) (
   input logic       clock,
   input logic       reset,
   aosp_req_if.sink  req_port,
   aosp_rsp_if.source rsp_port,
   aosp_csr_if.sink  csr_port
);

   // Accumulator widths follow the block length: 11-bit unsigned channels
   // grow by log2(block), signed channels the same from 12 bits.
   localparam int CNT_W      = $clog2(BLOCK_SAMPLES);
   localparam int UNS_SUM_W  = VOLT_RAW_W + CNT_W;
   localparam int SGN_SUM_W  = CURR_RAW_W + CNT_W;
   localparam int WIDE_W     = SGN_SUM_W + 1;
   localparam int PROD_W     = 2 * SCALE_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_SAMPLES - 1);
   localparam logic [WIDE_W-1:0] SAT_MAX = WIDE_W'(16'hFFFF);

   // ------------------------------------------------------------------
   // Scale registers, written through the CSR channel (always ready).
   // ------------------------------------------------------------------
   logic [SCALE_W-1:0] vscale_ff, cscale_ff, lscale_ff, tscale_ff;
   logic               csr_fire;

   assign csr_port.ready = 1'b1;
   assign csr_fire       = csr_port.valid && csr_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vscale_ff <= VOLTAGE_SCALE_RST;
         cscale_ff <= CURRENT_SCALE_RST;
         lscale_ff <= LIGHT_SCALE_RST;
         tscale_ff <= TEMP_SCALE_RST;
      end else if (csr_fire) begin
         case (csr_index_type'(csr_port.index))
            CSR_VOLTAGE_SCALE:     vscale_ff <= csr_port.data;
            CSR_CURRENT_SCALE:     cscale_ff <= csr_port.data;
            CSR_LIGHT_SCALE:       lscale_ff <= csr_port.data;
            CSR_TEMPERATURE_SCALE: tscale_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake: stage 1 register feeds the result register. Both move
   // when the result register is empty or being taken.
   // ------------------------------------------------------------------
   logic s1_valid_ff, rsp_valid_ff;
   logic out_en, req_fire;

   assign out_en         = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = !s1_valid_ff || out_en;
   assign req_fire       = req_port.valid && req_port.ready;

   // ------------------------------------------------------------------
   // Stage 1: accumulate, track peaks, detect block end.
   // ------------------------------------------------------------------
   logic        [CNT_W-1:0]     cnt_ff, cnt_in;
   logic        [UNS_SUM_W-1:0] vsum_ff, vsum_in, vsum_acc;
   logic signed [SGN_SUM_W-1:0] csum_ff, csum_in, csum_acc;
   logic signed [SGN_SUM_W-1:0] lsum_ff, lsum_in, lsum_acc;
   logic        [UNS_SUM_W-1:0] tsum_ff, tsum_in, tsum_acc;
   logic        [VOLT_RAW_W-1:0] min_ff, min_in;
   logic        [VOLT_RAW_W-1:0] max_ff, max_in;
   logic                        is_read, blk_end;

   // Snapshot handed to stage 2
   logic                        s1_read_ff, s1_end_ff;
   logic        [UNS_SUM_W-1:0] s1_vsum_ff, s1_tsum_ff;
   logic signed [SGN_SUM_W-1:0] s1_csum_ff, s1_lsum_ff;
   logic        [VOLT_RAW_W-1:0] s1_min_ff, s1_max_ff;

   always_comb begin
      is_read  = (req_port.cmd == CMD_READ_PEAKS);
      vsum_acc = vsum_ff + UNS_SUM_W'(req_port.voltage_raw);
      csum_acc = csum_ff + SGN_SUM_W'(req_port.current_raw);
      lsum_acc = lsum_ff + SGN_SUM_W'(req_port.light_raw);
      tsum_acc = tsum_ff + UNS_SUM_W'(req_port.temperature_raw);
      blk_end  = (cnt_ff == CNT_LAST);

      cnt_in  = cnt_ff;
      vsum_in = vsum_ff;
      csum_in = csum_ff;
      lsum_in = lsum_ff;
      tsum_in = tsum_ff;
      min_in  = min_ff;
      max_in  = max_ff;

      if (is_read) begin
         // peak read: trackers restart, sums untouched
         min_in = MIN_TRACK_RESET;
         max_in = MAX_TRACK_RESET;
      end else begin
         if (req_port.voltage_raw < min_ff) begin
            min_in = req_port.voltage_raw;
         end
         // only positive currents can raise the max
         if (!req_port.current_raw[CURR_RAW_W-1] &&
             (req_port.current_raw[VOLT_RAW_W-1:0] > max_ff)) begin
            max_in = req_port.current_raw[VOLT_RAW_W-1:0];
         end
         if (blk_end) begin
            cnt_in  = '0;
            vsum_in = '0;
            csum_in = '0;
            lsum_in = '0;
            tsum_in = '0;
         end else begin
            cnt_in  = cnt_ff + 1'b1;
            vsum_in = vsum_acc;
            csum_in = csum_acc;
            lsum_in = lsum_acc;
            tsum_in = tsum_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         vsum_ff     <= '0;
         csum_ff     <= '0;
         lsum_ff     <= '0;
         tsum_ff     <= '0;
         min_ff      <= MIN_TRACK_RESET;
         max_ff      <= MAX_TRACK_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            cnt_ff  <= cnt_in;
            vsum_ff <= vsum_in;
            csum_ff <= csum_in;
            lsum_ff <= lsum_in;
            tsum_ff <= tsum_in;
            min_ff  <= min_in;
            max_ff  <= max_in;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (out_en) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_read_ff <= is_read;
         s1_end_ff  <= !is_read && blk_end;
         s1_vsum_ff <= vsum_acc;
         s1_csum_ff <= csum_acc;
         s1_lsum_ff <= lsum_acc;
         s1_tsum_ff <= tsum_acc;
         s1_min_ff  <= min_ff;   // values before the read clears them
         s1_max_ff  <= max_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: decimate and scale. Shift, saturate to 16 bits, Q16 multiply.
   // ------------------------------------------------------------------
   function automatic logic [SCALE_W-1:0] sat_shift(input logic [WIDE_W-1:0] sum);
      logic [WIDE_W-1:0] sh;
      sh = sum >> SUM_SHIFT;
      if (sh > SAT_MAX) begin
         return '1;
      end
      return sh[SCALE_W-1:0];
   endfunction

   logic [SCALE_W-1:0]    v_dec, c_dec, l_dec, t_dec;
   logic [PROD_W-1:0]     v_prod, c_prod, l_prod, t_prod, minv_prod, maxc_prod;
   logic                  c_pos, l_pos;
   logic [TEMP_OUT_W-1:0] t_meas;

   logic [MEAS_W-1:0]     held_v_ff, held_v_in;
   logic [MEAS_W-1:0]     held_c_ff, held_c_in;
   logic [MEAS_W-1:0]     held_l_ff, held_l_in;
   logic [TEMP_OUT_W-1:0] held_t_ff, held_t_in;

   logic                  rsp_ready_flag_ff;
   logic [MEAS_W-1:0]     rsp_minv_ff, rsp_minv_in, rsp_maxc_ff, rsp_maxc_in;

   always_comb begin
      c_pos = !s1_csum_ff[SGN_SUM_W-1] && (s1_csum_ff != '0);
      l_pos = !s1_lsum_ff[SGN_SUM_W-1] && (s1_lsum_ff != '0);

      v_dec = sat_shift(WIDE_W'(s1_vsum_ff));
      c_dec = sat_shift(WIDE_W'($unsigned(s1_csum_ff)));
      l_dec = sat_shift(WIDE_W'($unsigned(s1_lsum_ff)));
      t_dec = sat_shift(WIDE_W'(s1_tsum_ff));

      v_prod = PROD_W'(v_dec) * PROD_W'(vscale_ff);
      c_prod = PROD_W'(c_dec) * PROD_W'(cscale_ff);
      l_prod = PROD_W'(l_dec) * PROD_W'(lscale_ff);
      t_prod = PROD_W'(t_dec) * PROD_W'(tscale_ff);

      // peaks: raw * 4, rounded Q16
      minv_prod = PROD_W'({s1_min_ff, 2'b00}) * PROD_W'(vscale_ff) + Q16_HALF;
      maxc_prod = PROD_W'({s1_max_ff, 2'b00}) * PROD_W'(cscale_ff) + Q16_HALF;

      t_meas = TEMP_OUT_W'(t_prod[PROD_W-1:SCALE_W]) - TEMP_OFFSET;

      held_v_in = held_v_ff;
      held_c_in = held_c_ff;
      held_l_in = held_l_ff;
      held_t_in = held_t_ff;
      if (s1_end_ff) begin
         held_v_in = v_prod[PROD_W-1:SCALE_W];
         held_c_in = c_pos ? c_prod[PROD_W-1:SCALE_W] : '0;
         held_l_in = l_pos ? l_prod[PROD_W-1:SCALE_W] : '0;
         held_t_in = t_meas;
      end

      rsp_minv_in = s1_read_ff ? minv_prod[PROD_W-1:SCALE_W] : '0;
      rsp_maxc_in = s1_read_ff ? maxc_prod[PROD_W-1:SCALE_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_v_ff    <= '0;
         held_c_ff    <= '0;
         held_l_ff    <= '0;
         held_t_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            held_v_ff <= held_v_in;
            held_c_ff <= held_c_in;
            held_l_ff <= held_l_in;
            held_t_ff <= held_t_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_ready_flag_ff <= s1_end_ff;
         rsp_minv_ff       <= rsp_minv_in;
         rsp_maxc_ff       <= rsp_maxc_in;
      end
   end

   // Result item: held measurements sit directly behind the result register
   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.measure_ready      = rsp_ready_flag_ff;
   assign rsp_port.voltage_mv         = held_v_ff;
   assign rsp_port.current_ma         = held_c_ff;
   assign rsp_port.light_lux          = held_l_ff;
   assign rsp_port.temperature_tenths = $signed(held_t_ff);
   assign rsp_port.min_voltage_mv     = rsp_minv_ff;
   assign rsp_port.max_current_ma     = rsp_maxc_ff;

`ifndef SYNTHESIS
   // the last sample of a block wraps the counter and clears the sums
   a_block_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_port.cmd == CMD_SAMPLE) && (cnt_ff == CNT_LAST))
      |=> (cnt_ff == '0) && (vsum_ff == '0) && (tsum_ff == '0))
      else $error("block counter or sums did not restart at block end");

   // a peak read restarts both trackers
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_port.cmd == CMD_READ_PEAKS))
      |=> (min_ff == MIN_TRACK_RESET) && (max_ff == MAX_TRACK_RESET))
      else $error("peak trackers not reset by read item");

   // a read item reaches the output and never flags a finished block
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (out_en && s1_valid_ff && s1_read_ff)
      |=> rsp_valid_ff && !rsp_ready_flag_ff)
      else $error("read item reported a block completion");

   // a stalled result leaves the held measurements alone
   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_port.ready)
      |=> $stable(held_v_ff) && $stable(held_t_ff))
      else $error("held measurement changed while result stalled");
`endif

endmodule
